[rtl/msds_pkg.sv]
// Shared types and constants for the multiplexed segment display scanner.
// Holds the stream layout widths, operation and register codes, the controller
// states and the command and status bundles between controller and datapath.
package msds_pkg;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_POSITION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_INVERT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_INVERT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_MSB_FIRST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_USED      = 3'd7;

    // Item operation codes; the remaining codes are ignored.
    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_CHAR = 3'd1,
        OP_DOT  = 3'd2,
        OP_SPEC = 3'd3,
        OP_FONT = 3'd4
    } msds_op_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DOT_WR,
        ST_DIG_RD,
        ST_DIG_CHAR,
        ST_SEARCH,
        ST_EMIT
    } msds_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic tick;
        logic char_wr;
        logic dot_rd;
        logic dot_wr;
        logic spec_wr;
        logic font_wr;
        logic dig_rd;
        logic dig_latch;
        logic font_start;
        logic font_next;
        logic seg_raw;
        logic seg_hit;
        logic seg_miss;
        logic emit;
    } msds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        msds_op_t op;
        logic     frame_due;
        logic     scan_empty;
        logic     spec_hit;
        logic     font_none;
        logic     font_match;
        logic     font_last;
        logic     digit_last;
        logic     out_free;
    } msds_sts_t;

endpackage

[rtl/msds_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing else.
module msds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/msds_ctrl.sv]
// Controller state machine of the display scanner: sequences item execution,
// the per-digit font search and result emission. Depends on msds_pkg.
module msds_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  msds_pkg::msds_sts_t sts,
    output msds_pkg::msds_cmd_t cmd
);
    import msds_pkg::*;

    msds_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (sts.op)
                    OP_TICK: begin
                        if (sts.frame_due && !sts.scan_empty) state_next = ST_DIG_RD;
                        else state_next = ST_IDLE;
                    end
                    OP_DOT:  state_next = ST_DOT_WR;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DOT_WR:   state_next = ST_IDLE;
            ST_DIG_RD:   state_next = ST_DIG_CHAR;
            ST_DIG_CHAR: begin
                if (sts.spec_hit || sts.font_none) state_next = ST_EMIT;
                else state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (sts.font_match || sts.font_last) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    if (sts.digit_last) state_next = ST_IDLE;
                    else state_next = ST_DIG_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_EXEC: begin
                unique case (sts.op)
                    OP_TICK: cmd.tick    = 1'b1;
                    OP_CHAR: cmd.char_wr = 1'b1;
                    OP_DOT:  cmd.dot_rd  = 1'b1;
                    OP_SPEC: cmd.spec_wr = 1'b1;
                    OP_FONT: cmd.font_wr = 1'b1;
                    default: ;
                endcase
            end
            ST_DOT_WR: cmd.dot_wr = 1'b1;
            ST_DIG_RD: cmd.dig_rd = 1'b1;
            ST_DIG_CHAR: begin
                cmd.dig_latch = 1'b1;
                if (sts.spec_hit) cmd.seg_raw = 1'b1;
                else if (sts.font_none) cmd.seg_miss = 1'b1;
                else cmd.font_start = 1'b1;
            end
            ST_SEARCH: begin
                if (sts.font_match) cmd.seg_hit = 1'b1;
                else if (sts.font_last) cmd.seg_miss = 1'b1;
                else cmd.font_next = 1'b1;
            end
            ST_EMIT: cmd.emit = sts.out_free;
            default: ;
        endcase
    end

    // At most one buffer or table update, tick or emission per cycle.
    a_one_action: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.char_wr, cmd.dot_wr, cmd.spec_wr, cmd.font_wr, cmd.tick, cmd.emit}))
        else $error("several actions commanded together");

    // A dot read is always followed by its write-back.
    a_dot_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dot_rd |=> cmd.dot_wr)
        else $error("dot read without write-back");

    // An emission leaves the scan either idle or reading the next digit.
    a_emit_next: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (state_reg == ST_IDLE || state_reg == ST_DIG_RD))
        else $error("bad state after emission");

endmodule

[rtl/msds_dpath.sv]
// Datapath of the display scanner: configuration, item register, character
// buffer and font memories, tick counter, search index and result register.
// Depends on msds_pkg and msds_ram.
module msds_dpath #(
    parameter int MAX_DIGITS   = 32,
    parameter int FONT_ENTRIES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [msds_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [msds_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msds_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [msds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msds_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  msds_pkg::msds_cmd_t               cmd,
    output msds_pkg::msds_sts_t               sts
);
    import msds_pkg::*;

    localparam int CHAR_AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int FONT_AW  = $clog2(FONT_ENTRIES);
    localparam int FONT_CW  = $clog2(FONT_ENTRIES + 1);
    localparam int SCAN_MAX = (MAX_DIGITS < 32) ? MAX_DIGITS : 32;
    localparam logic [6:0] MAX_DIGITS_W   = 7'(MAX_DIGITS);
    localparam logic [8:0] FONT_ENTRIES_W = 9'(FONT_ENTRIES);
    localparam logic [5:0] SCAN_MAX_W     = 6'(SCAN_MAX);

    // Configuration registers.
    logic [5:0]  cfg_digit_count_reg;
    logic        cfg_spec_en_reg;
    logic [4:0]  cfg_spec_pos_reg;
    logic [15:0] cfg_interval_reg;
    logic        cfg_seg_inv_reg;
    logic        cfg_grid_inv_reg;
    logic        cfg_msb_first_reg;
    logic [6:0]  cfg_font_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_digit_count_reg <= 6'd8;
            cfg_spec_en_reg     <= 1'b0;
            cfg_spec_pos_reg    <= 5'd0;
            cfg_interval_reg    <= 16'd1;
            cfg_seg_inv_reg     <= 1'b0;
            cfg_grid_inv_reg    <= 1'b0;
            cfg_msb_first_reg   <= 1'b1;
            cfg_font_used_reg   <= 7'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DIGIT_COUNT:    cfg_digit_count_reg <= cfg_wr_data[5:0];
                CFG_SPEC_ENABLE:    cfg_spec_en_reg     <= cfg_wr_data[0];
                CFG_SPEC_POSITION:  cfg_spec_pos_reg    <= cfg_wr_data[4:0];
                CFG_FRAME_INTERVAL: cfg_interval_reg    <= cfg_wr_data;
                CFG_SEGMENT_INVERT: cfg_seg_inv_reg     <= cfg_wr_data[0];
                CFG_GRID_INVERT:    cfg_grid_inv_reg    <= cfg_wr_data[0];
                CFG_SEG_MSB_FIRST:  cfg_msb_first_reg   <= cfg_wr_data[0];
                CFG_FONT_USED:      cfg_font_used_reg   <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // Item register, loaded when an input beat is taken.
    logic [2:0] item_op_reg;
    logic [4:0] item_pos_reg;
    logic [7:0] item_char_reg;
    logic       item_bit_reg;
    logic [2:0] item_sbit_reg;
    logic [5:0] item_slot_reg;
    logic [7:0] item_fchar_reg;
    logic [7:0] item_fseg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_op_reg    <= s_tuser[2:0];
            item_pos_reg   <= s_tdata[4:0];
            item_char_reg  <= s_tdata[12:5];
            item_bit_reg   <= s_tdata[13];
            item_sbit_reg  <= s_tdata[16:14];
            item_slot_reg  <= s_tdata[22:17];
            item_fchar_reg <= s_tdata[30:23];
            item_fseg_reg  <= s_tdata[38:31];
        end
    end

    // Tick counter and frame timing.
    logic [15:0] tick_reg;
    logic [15:0] interval;
    logic [15:0] tick_inc;
    logic        frame_due;

    assign interval  = (cfg_interval_reg == 16'd0) ? 16'd1 : cfg_interval_reg;
    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign frame_due = (tick_inc >= interval);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= 16'd0;
        end else if (cmd.tick) begin
            tick_reg <= frame_due ? 16'd0 : tick_inc;
        end
    end

    // Digit counter and frame length.
    logic [5:0] digit_reg;
    logic [5:0] scan_count;
    logic       digit_last;
    logic       spec_hit;

    assign scan_count = (cfg_digit_count_reg > SCAN_MAX_W) ? SCAN_MAX_W : cfg_digit_count_reg;
    assign digit_last = ((digit_reg + 6'd1) == scan_count);
    assign spec_hit   = cfg_spec_en_reg && (digit_reg == {1'b0, cfg_spec_pos_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= 6'd0;
        end else if (cmd.tick && frame_due) begin
            digit_reg <= 6'd0;
        end else if (cmd.emit) begin
            digit_reg <= digit_reg + 6'd1;
        end
    end

    // Character buffer with per-entry valid bits; an unwritten entry reads zero.
    logic [MAX_DIGITS-1:0] char_valid_reg;
    logic                  char_rd_valid_reg;
    logic                  char_wr_en;
    logic [CHAR_AW-1:0]    char_wr_addr;
    logic [7:0]            char_wr_data;
    logic                  char_rd_en;
    logic [CHAR_AW-1:0]    char_rd_addr;
    logic [7:0]            char_rd_data;
    logic [7:0]            char_q;
    logic [7:0]            special_reg;
    logic [7:0]            special_new;
    logic                  pos_ok;
    logic                  spec_pos_ok;
    logic                  dot_blocked;

    assign pos_ok      = ({2'b00, item_pos_reg} < MAX_DIGITS_W);
    assign spec_pos_ok = ({2'b00, cfg_spec_pos_reg} < MAX_DIGITS_W);
    assign dot_blocked = cfg_spec_en_reg && (item_pos_reg == cfg_spec_pos_reg);
    assign special_new = item_bit_reg ? (special_reg | (8'h01 << item_sbit_reg))
                                      : (special_reg & ~(8'h01 << item_sbit_reg));
    assign char_q      = char_rd_valid_reg ? char_rd_data : 8'h00;
    assign char_rd_en  = cmd.dot_rd | cmd.dig_rd;
    assign char_rd_addr = cmd.dig_rd ? CHAR_AW'(digit_reg) : CHAR_AW'(item_pos_reg);

    // Buffer write selection for character, dot and special updates.
    always_comb begin
        char_wr_en   = 1'b0;
        char_wr_addr = CHAR_AW'(item_pos_reg);
        char_wr_data = item_char_reg;
        if (cmd.char_wr) begin
            char_wr_en = pos_ok;
        end else if (cmd.dot_wr) begin
            char_wr_en   = pos_ok && !dot_blocked;
            char_wr_data = {item_bit_reg, char_q[6:0]};
        end else if (cmd.spec_wr) begin
            char_wr_en   = cfg_spec_en_reg && spec_pos_ok;
            char_wr_addr = CHAR_AW'(cfg_spec_pos_reg);
            char_wr_data = special_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_valid_reg <= '0;
            special_reg    <= 8'h00;
        end else begin
            if (char_wr_en) char_valid_reg[char_wr_addr] <= 1'b1;
            if (cmd.spec_wr && cfg_spec_en_reg) special_reg <= special_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (char_rd_en) char_rd_valid_reg <= char_valid_reg[char_rd_addr];
    end

    msds_ram #(
        .WIDTH (8),
        .DEPTH (MAX_DIGITS)
    ) u_char_ram (
        .aclk    (aclk),
        .wr_en   (char_wr_en),
        .wr_addr (char_wr_addr),
        .wr_data (char_wr_data),
        .rd_en   (char_rd_en),
        .rd_addr (char_rd_addr),
        .rd_data (char_rd_data)
    );

    // Font table: pattern in the upper byte, key in the lower byte.
    logic               font_wr_en;
    logic               font_rd_en;
    logic [FONT_AW-1:0] font_rd_addr;
    logic [15:0]        font_rd_data;
    logic [FONT_CW-1:0] font_k_reg;
    logic [FONT_CW-1:0] font_k_plus;
    logic [8:0]         font_used9;
    logic [8:0]         font_lim9;
    logic [FONT_CW-1:0] font_lim;
    logic [7:0]         cur_char_reg;
    logic [7:0]         seg_reg;

    assign font_wr_en   = cmd.font_wr && ({3'b000, item_slot_reg} < FONT_ENTRIES_W);
    assign font_used9   = {2'b00, cfg_font_used_reg};
    assign font_lim9    = (font_used9 < FONT_ENTRIES_W) ? font_used9 : FONT_ENTRIES_W;
    assign font_lim     = font_lim9[FONT_CW-1:0];
    assign font_k_plus  = font_k_reg + FONT_CW'(1);
    assign font_rd_en   = cmd.font_start | cmd.font_next;
    assign font_rd_addr = cmd.font_start ? '0 : font_k_plus[FONT_AW-1:0];

    msds_ram #(
        .WIDTH (16),
        .DEPTH (FONT_ENTRIES)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (font_wr_en),
        .wr_addr (FONT_AW'(item_slot_reg)),
        .wr_data ({item_fseg_reg, item_fchar_reg}),
        .rd_en   (font_rd_en),
        .rd_addr (font_rd_addr),
        .rd_data (font_rd_data)
    );

    // Search index, searched character and chosen segment byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_k_reg <= '0;
        end else if (cmd.font_start) begin
            font_k_reg <= '0;
        end else if (cmd.font_next) begin
            font_k_reg <= font_k_plus;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dig_latch) cur_char_reg <= char_q;
        if (cmd.seg_raw) seg_reg <= char_q;
        else if (cmd.seg_hit) seg_reg <= font_rd_data[15:8];
        else if (cmd.seg_miss) seg_reg <= 8'h00;
    end

    // Result register, holding one beat until the sink takes it.
    logic        out_valid_reg;
    logic [4:0]  out_digit_reg;
    logic [31:0] out_grid_reg;
    logic [7:0]  out_seg_reg;
    logic        out_order_reg;
    logic        out_last_reg;
    logic [31:0] grid_onehot;

    assign grid_onehot = 32'h1 << digit_reg[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_digit_reg <= digit_reg[4:0];
            out_grid_reg  <= cfg_grid_inv_reg ? ~grid_onehot : grid_onehot;
            out_seg_reg   <= cfg_seg_inv_reg ? ~seg_reg : seg_reg;
            out_order_reg <= spec_hit | cfg_msb_first_reg;
            out_last_reg  <= digit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_order_reg, out_seg_reg, out_grid_reg, out_digit_reg};
    assign m_tlast  = out_last_reg;

    // Status towards the controller.
    always_comb begin
        sts            = '0;
        sts.op         = msds_op_t'(item_op_reg);
        sts.frame_due  = frame_due;
        sts.scan_empty = (scan_count == 6'd0);
        sts.spec_hit   = spec_hit;
        sts.font_none  = (font_lim == '0);
        sts.font_match = (font_rd_data[7:0] == cur_char_reg);
        sts.font_last  = (font_k_plus == font_lim);
        sts.digit_last = digit_last;
        sts.out_free   = !out_valid_reg || m_tready;
    end

    // A new result is only loaded when the previous one is gone.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // A held result always selects exactly one digit.
    a_grid_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($onehot(out_grid_reg) || $onehot(~out_grid_reg)))
        else $error("grid word not one-hot");

    // The search index restarts at zero.
    a_search_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.font_start |=> (font_k_reg == '0))
        else $error("font search did not restart");

endmodule

[rtl/multiplexed_segment_display_scanner.sv]
// Multiplexed segment display scanner. Each write item passes through the
// execute state, a dot item also through a write-back state, and a tick that
// completes the frame interval starts a frame of one result per digit. Each
// digit passes through a buffer read, a character step and emission; unless
// it is the special position or no font entry is in use, the sequential
// first-match search comes in between and reads one font entry per cycle (up
// to min(font_entries_used, FONT_ENTRIES) entries). Emission waits while the
// sink holds m_tready low and the previous result is still held.
// No input beat is taken during a frame.
// Depends on msds_pkg, msds_ram, msds_ctrl and msds_dpath.
module multiplexed_segment_display_scanner #(
    parameter int MAX_DIGITS   = 32,
    parameter int FONT_ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input beats.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // position, char_code, bit_value, spec_bit, font_slot, font_char,
    // font_segments, zero pad
    input  logic [msds_pkg::S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [msds_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result beats.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // digit, grid_word, segment_byte, segment_msb_order, zero pad
    output logic [msds_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [msds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msds_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import msds_pkg::*;

    msds_cmd_t cmd;
    msds_sts_t sts;

    // Sequencing.
    msds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage and arithmetic.
    msds_dpath #(
        .MAX_DIGITS   (MAX_DIGITS),
        .FONT_ENTRIES (FONT_ENTRIES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

[tb/multiplexed_segment_display_scanner_tb.sv]
// Self-checking testbench for the multiplexed segment display scanner.
// Depends on msds_pkg and the scanner RTL; drives item beats, configures the
// block and checks every digit beat against a behavioural model of the scanner.
module multiplexed_segment_display_scanner_tb;
    import msds_pkg::*;

    localparam int NUM_DIGITS   = 32;
    localparam int NUM_FONT     = 64;
    // A full frame is at most 32 digits, each searching up to 64 font entries.
    localparam int DRAIN_CYCLES = 2200;
    localparam int QUIET_LIMIT  = 20000;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    typedef struct {
        logic [2:0] op;
        logic [4:0] position;
        logic [7:0] char_code;
        logic       bit_value;
        logic [2:0] spec_bit;
        logic [5:0] font_slot;
        logic [7:0] font_char;
        logic [7:0] font_segments;
    } display_item_t;

    typedef struct {
        logic [4:0]  digit;
        logic [31:0] grid_word;
        logic [7:0]  segment_byte;
        logic        msb_order;
        logic        last;
    } digit_drive_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Behavioural copy of the display state and the configuration.
    logic [7:0]  mdl_chars [NUM_DIGITS] = '{default: 8'h00};
    logic [7:0]  mdl_font_key [NUM_FONT] = '{default: 8'h00};
    logic [7:0]  mdl_font_pat [NUM_FONT] = '{default: 8'h00};
    logic [7:0]  mdl_spec_byte = 8'h00;
    logic [15:0] mdl_ticks = 16'd0;
    logic [5:0]  cfg_digits = 6'd8;
    logic        cfg_spec_en = 1'b0;
    logic [4:0]  cfg_spec_pos = 5'd0;
    logic [15:0] cfg_interval = 16'd1;
    logic        cfg_seg_inv = 1'b0;
    logic        cfg_grid_inv = 1'b0;
    logic        cfg_msb_first = 1'b1;
    logic [6:0]  cfg_font_used = 7'd0;

    digit_drive_t pending_drives[$];
    digit_drive_t oldest;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    multiplexed_segment_display_scanner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // First-match search over the active part of the font table.
    function automatic logic [7:0] font_search(input logic [7:0] code);
        int n;
        logic hit;
        logic [7:0] pattern;
        n = (cfg_font_used > NUM_FONT) ? NUM_FONT : cfg_font_used;
        hit = 1'b0;
        pattern = 8'h00;
        for (int k = 0; k < n && !hit; k++) begin
            if (mdl_font_key[k] == code) begin
                hit = 1'b1;
                pattern = mdl_font_pat[k];
            end
        end
        return pattern;
    endfunction

    // Queue one digit beat per scanned position.
    task automatic scan_frame();
        int n;
        digit_drive_t d;
        logic [7:0] seg;
        n = (cfg_digits > NUM_DIGITS) ? NUM_DIGITS : cfg_digits;
        for (int i = 0; i < n; i++) begin
            d.digit = 5'(i);
            d.grid_word = 32'h1 << i;
            if (cfg_grid_inv) begin
                d.grid_word = ~d.grid_word;
            end
            if (cfg_spec_en && i == cfg_spec_pos) begin
                seg = mdl_chars[i];
                d.msb_order = 1'b1;
            end else begin
                seg = font_search(mdl_chars[i]);
                d.msb_order = cfg_msb_first;
            end
            d.segment_byte = cfg_seg_inv ? ~seg : seg;
            d.last = (i == n - 1);
            pending_drives.push_back(d);
        end
    endtask

    // Apply one accepted item to the model.
    task automatic update_display(input display_item_t it);
        logic [15:0] interval;
        case (it.op)
            OP_CHAR: begin
                mdl_chars[it.position] = it.char_code;
            end
            OP_DOT: begin
                if (!(cfg_spec_en && it.position == cfg_spec_pos)) begin
                    mdl_chars[it.position][7] = it.bit_value;
                end
            end
            OP_SPEC: begin
                if (cfg_spec_en) begin
                    mdl_spec_byte[it.spec_bit] = it.bit_value;
                    mdl_chars[cfg_spec_pos] = mdl_spec_byte;
                end
            end
            OP_FONT: begin
                mdl_font_key[it.font_slot] = it.font_char;
                mdl_font_pat[it.font_slot] = it.font_segments;
            end
            OP_TICK: begin
                interval = (cfg_interval == 16'd0) ? 16'd1 : cfg_interval;
                if (mdl_ticks != 16'hFFFF) begin
                    mdl_ticks = mdl_ticks + 16'd1;
                end
                if (mdl_ticks >= interval) begin
                    mdl_ticks = 16'd0;
                    scan_frame();
                end
            end
            default: begin
            end
        endcase
    endtask

    // Character codes are drawn mostly from the range that the font keys use.
    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7) begin
            c = {c[7], 3'b011, c[3:0]};
        end
        return c;
    endfunction

    function automatic display_item_t any_item();
        display_item_t it;
        int w;
        w = $urandom_range(0, 99);
        if (w < 35) it.op = OP_TICK;
        else if (w < 58) it.op = OP_CHAR;
        else if (w < 70) it.op = OP_DOT;
        else if (w < 82) it.op = OP_SPEC;
        else if (w < 94) it.op = OP_FONT;
        else it.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        it.position = 5'($urandom_range(0, 31));
        it.char_code = pick_code();
        it.bit_value = 1'($urandom_range(0, 1));
        it.spec_bit = 3'($urandom_range(0, 7));
        it.font_slot = 6'($urandom_range(0, 63));
        it.font_char = pick_code();
        it.font_segments = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Send one item beat and update the model once it has been taken.
    task automatic send_item(input display_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {1'b0, it.font_segments, it.font_char, it.font_slot, it.spec_bit,
                    it.bit_value, it.char_code, it.position};
        do @(posedge aclk); while (!s_tready);
        update_display(it);
    endtask

    task automatic send_op(input logic [2:0] op);
        display_item_t it;
        it = any_item();
        it.op = op;
        send_item(it);
    endtask

    task automatic send_char(input logic [4:0] pos, input logic [7:0] code);
        display_item_t it;
        it = any_item();
        it.op = OP_CHAR;
        it.position = pos;
        it.char_code = code;
        send_item(it);
    endtask

    task automatic send_dot(input logic [4:0] pos, input logic value);
        display_item_t it;
        it = any_item();
        it.op = OP_DOT;
        it.position = pos;
        it.bit_value = value;
        send_item(it);
    endtask

    task automatic send_spec(input logic [2:0] bit_idx, input logic value);
        display_item_t it;
        it = any_item();
        it.op = OP_SPEC;
        it.spec_bit = bit_idx;
        it.bit_value = value;
        send_item(it);
    endtask

    task automatic send_font(input logic [5:0] slot, input logic [7:0] key,
                             input logic [7:0] pattern);
        display_item_t it;
        it = any_item();
        it.op = OP_FONT;
        it.font_slot = slot;
        it.font_char = key;
        it.font_segments = pattern;
        send_item(it);
    endtask

    // Write one register; the enable is low for a cycle between writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DIGIT_COUNT:    cfg_digits = 6'(value);
            CFG_SPEC_ENABLE:    cfg_spec_en = 1'(value);
            CFG_SPEC_POSITION:  cfg_spec_pos = 5'(value);
            CFG_FRAME_INTERVAL: cfg_interval = 16'(value);
            CFG_SEGMENT_INVERT: cfg_seg_inv = 1'(value);
            CFG_GRID_INVERT:    cfg_grid_inv = 1'(value);
            CFG_SEG_MSB_FIRST:  cfg_msb_first = 1'(value);
            CFG_FONT_USED:      cfg_font_used = 7'(value);
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Wait until every queued digit beat has arrived and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 87; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            IDLE_BOTH:     begin send_idle_pct = 38; recv_stall_pct = 38; end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Default settings: eight blank digits on the first tick.
    task automatic test_reset_state();
        send_op(OP_TICK);
    endtask

    // Font lookup with a duplicate key, a key of zero and a miss.
    task automatic test_font_lookup();
        send_font(6'd0, 8'h31, 8'h06);
        send_font(6'd1, 8'h32, 8'h5B);
        send_font(6'd2, 8'h31, 8'hFF);
        send_font(6'd63, 8'h00, 8'h3F);
        settle();
        write_reg(CFG_FONT_USED, 2);
        write_reg(CFG_DIGIT_COUNT, 63);
        send_char(5'd0, 8'h31);
        send_char(5'd1, 8'h32);
        send_char(5'd31, 8'hFF);
        send_op(OP_TICK);
    endtask

    // Dot bit set and clear, including one that turns a hit into a miss.
    task automatic test_dot_bits();
        send_dot(5'd1, 1'b1);
        send_dot(5'd0, 1'b0);
        send_dot(5'd31, 1'b0);
        send_op(OP_TICK);
    endtask

    // Special byte writes, the dot ignored there, and writes while disabled.
    task automatic test_special_position();
        settle();
        write_reg(CFG_SPEC_ENABLE, 1);
        write_reg(CFG_SPEC_POSITION, 0);
        send_spec(3'd7, 1'b1);
        send_spec(3'd0, 1'b1);
        send_dot(5'd0, 1'b0);
        send_op(OP_TICK);
        settle();
        write_reg(CFG_SPEC_POSITION, 31);
        write_reg(CFG_DIGIT_COUNT, 1);
        send_spec(3'd0, 1'b0);
        send_op(OP_TICK);
        settle();
        write_reg(CFG_SPEC_ENABLE, 0);
        write_reg(CFG_DIGIT_COUNT, 32);
        send_spec(3'd1, 1'b1);
        send_op(OP_TICK);
    endtask

    // Segment and grid inversion and the other shift order. The middle of the
    // font table is filled with keys that the buffer does not hold, so that a
    // search over the whole table runs to its end.
    task automatic test_output_options();
        for (int slot = 3; slot < NUM_FONT - 1; slot++) begin
            send_font(6'(slot), 8'(8'hC0 + slot), 8'($urandom_range(0, 255)));
        end
        settle();
        write_reg(CFG_SEGMENT_INVERT, 1);
        write_reg(CFG_GRID_INVERT, 1);
        write_reg(CFG_SEG_MSB_FIRST, 0);
        write_reg(CFG_FONT_USED, 127);
        write_reg(CFG_DIGIT_COUNT, 4);
        send_op(OP_TICK);
    endtask

    // Frame interval of several ticks, of zero and of the maximum, and no digits.
    task automatic test_frame_timing();
        settle();
        write_reg(CFG_FRAME_INTERVAL, 3);
        repeat (3) send_op(OP_TICK);
        settle();
        write_reg(CFG_FRAME_INTERVAL, 0);
        send_op(OP_TICK);
        settle();
        write_reg(CFG_FRAME_INTERVAL, 65535);
        send_op(OP_TICK);
        settle();
        write_reg(CFG_FRAME_INTERVAL, 1);
        write_reg(CFG_DIGIT_COUNT, 0);
        send_op(OP_TICK);
        settle();
        write_reg(CFG_DIGIT_COUNT, 2);
        send_op(OP_TICK);
    endtask

    // Reserved operation codes change nothing.
    task automatic test_reserved_ops();
        send_op(OP_RSVD_LO);
        send_op(OP_RSVD_HI);
        send_op(OP_TICK);
    endtask

    // Fill the whole font table, then random traffic over several settings.
    task automatic test_random_traffic();
        for (int slot = 0; slot < NUM_FONT; slot++) begin
            send_font(6'(slot), pick_code(), 8'($urandom_range(0, 255)));
        end
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            set_idling(idling_t'(phase % 4));
            write_reg(CFG_DIGIT_COUNT, (phase == 1) ? 32 : $urandom_range(1, 8));
            write_reg(CFG_SPEC_ENABLE, (phase == 3) ? 1 : $urandom_range(0, 1));
            write_reg(CFG_SPEC_POSITION, (phase == 3) ? 31 : $urandom_range(0, 7));
            write_reg(CFG_FRAME_INTERVAL, $urandom_range(1, 3));
            write_reg(CFG_SEGMENT_INVERT, $urandom_range(0, 1));
            write_reg(CFG_GRID_INVERT, $urandom_range(0, 1));
            write_reg(CFG_SEG_MSB_FIRST, $urandom_range(0, 1));
            write_reg(CFG_FONT_USED, (phase == 2) ? 127 :
                                     (phase == 5) ? 64 : $urandom_range(0, 64));
            repeat (45) send_item(any_item());
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_font_lookup();
        test_dot_bits();
        test_special_position();
        test_output_options();
        test_frame_timing();
        test_reserved_ops();
        test_random_traffic();
        settle();
        if (error_count == 0) begin
            $display("multiplexed_segment_display_scanner_tb passed");
        end else begin
            $display("multiplexed_segment_display_scanner_tb failed");
        end
        $finish;
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each digit beat with the oldest queued one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                $error("unexpected digit beat: digit %0d", m_tdata[4:0]);
                error_count++;
            end else begin
                oldest = pending_drives.pop_front();
                if (m_tdata[4:0] !== oldest.digit) begin
                    $error("digit: expected %0d, actual %0d", oldest.digit, m_tdata[4:0]);
                    error_count++;
                end
                if (m_tdata[36:5] !== oldest.grid_word) begin
                    $error("grid_word: expected %h, actual %h",
                           oldest.grid_word, m_tdata[36:5]);
                    error_count++;
                end
                if (m_tdata[44:37] !== oldest.segment_byte) begin
                    $error("segment_byte: expected %h, actual %h",
                           oldest.segment_byte, m_tdata[44:37]);
                    error_count++;
                end
                if (m_tdata[45] !== oldest.msb_order) begin
                    $error("segment_msb_order: expected %0b, actual %0b",
                           oldest.msb_order, m_tdata[45]);
                    error_count++;
                end
                if (m_tlast !== oldest.last) begin
                    $error("last: expected %0b, actual %0b", oldest.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat and no register write is taken.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multiplexed_segment_display_scanner_tb failed");
            $finish;
        end
    end

endmodule
